FILE: design/cbbe_pkg.sv
// ----------------------------------------------------------------------------
// cbbe_pkg
// Shared types, codes and the biphase-mark coding function of the cassette
// block encoder.
// ----------------------------------------------------------------------------
package cbbe_pkg;

    localparam int POS_W = 8;
    localparam int SUM_W = 16;

    localparam logic [7:0] CODE_ZERO = 8'h00;
    localparam logic [7:0] CODE_SYNC = 8'h16;
    localparam logic [7:0] CODE_STX  = 8'h02;
    localparam logic [7:0] CODE_ETX  = 8'h03;

    typedef enum logic [2:0] {
        KIND_ZERO    = 3'd0,
        KIND_SYNC    = 3'd1,
        KIND_STX     = 3'd2,
        KIND_DATA    = 3'd3,
        KIND_ETX     = 3'd4,
        KIND_CSUM_LO = 3'd5,
        KIND_CSUM_HI = 3'd6
    } kind_t;

    // controller to datapath
    typedef struct packed {
        logic  accept;
        logic  emit;
        kind_t kind;
        logic  last;
    } cbbe_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic first_of_block;
        logic end_of_block;
        logic out_free;
    } cbbe_sts_t;

    typedef struct packed {
        logic [15:0] halves;
        logic        level;
    } coded_t;

    // lsb first, toggle at every bit start, toggle again mid-bit for a one
    function automatic coded_t biphase_encode(input logic [7:0] value, input logic level_in);
        coded_t res;
        logic   lvl;
        lvl        = level_in;
        res.halves = '0;
        for (int k = 0; k < 8; k++)
        begin
            lvl                = ~lvl;
            res.halves[2*k]    = lvl;
            lvl                = lvl ^ value[k];
            res.halves[2*k+1]  = lvl;
        end
        res.level = lvl;
        return res;
    endfunction

endpackage

FILE: design/cbbe_in_if.sv
// ----------------------------------------------------------------------------
// cbbe_in_if
// Input channel: one data byte per beat.
// ----------------------------------------------------------------------------
interface cbbe_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink (input valid, input data_byte, output ready);
endinterface

FILE: design/cbbe_out_if.sv
// ----------------------------------------------------------------------------
// cbbe_out_if
// Output channel: one coded byte per beat.
// ----------------------------------------------------------------------------
interface cbbe_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] half_bit_levels;
    logic [7:0]  coded_byte;
    logic [2:0]  byte_kind;
    logic        last_of_run;

    modport source (output valid, output half_bit_levels, output coded_byte,
                    output byte_kind, output last_of_run, input ready);
    modport sink (input valid, input half_bit_levels, input coded_byte,
                  input byte_kind, input last_of_run, output ready);
endinterface

FILE: design/cassette_block_biphase_encoder.sv
// ----------------------------------------------------------------------------
// cassette_block_biphase_encoder
// Frames tape blocks and codes every byte in biphase mark, one coded byte
// (16 half-bit levels) per output beat.
//
//   channel   dir   width  payload
//   in_ch     in    8      data_byte
//   out_ch    out   28     half_bit_levels, coded_byte, byte_kind, last_of_run
//
// a data byte is taken while idle; then, while the output register is free,
// its coded bytes follow: LEAD_ZEROS zeros, SYNC_BYTES syncs and stx before
// the first byte of a block, the data byte, etx and checksum lo, hi after the last.
// the sequencer emits one coded byte per cycle from a single output register
// out_ch stalls hold the sequencer; in_ch.ready is high only between items
// reset: line level high, block position and checksum cleared
// ----------------------------------------------------------------------------
module cassette_block_biphase_encoder
    import cbbe_pkg::*;
#(
    parameter int LEAD_ZEROS  = 32,
    parameter int SYNC_BYTES  = 3,
    parameter int BLOCK_BYTES = 256
)
(
    input logic               clk,
    input logic               rst_n,
    cbbe_in_if.sink           in_ch,
    cbbe_out_if.source        out_ch
);

    cbbe_cmd_t cmd;
    cbbe_sts_t sts;

    cbbe_ctrl #(
        .LEAD_ZEROS (LEAD_ZEROS),
        .SYNC_BYTES (SYNC_BYTES)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    cbbe_datapath #(
        .BLOCK_BYTES (BLOCK_BYTES)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sts             (sts),
        .data_byte       (in_ch.data_byte),
        .out_ready       (out_ch.ready),
        .out_valid       (out_ch.valid),
        .half_bit_levels (out_ch.half_bit_levels),
        .coded_byte      (out_ch.coded_byte),
        .byte_kind       (out_ch.byte_kind),
        .last_of_run     (out_ch.last_of_run)
    );

endmodule

FILE: design/cbbe_ctrl.sv
// ----------------------------------------------------------------------------
// cbbe_ctrl
// Sequencer that walks the frame of a block: lead zeros, sync, stx, data,
// etx and checksum, one coded byte per output slot.
// ----------------------------------------------------------------------------
module cbbe_ctrl
    import cbbe_pkg::*;
#(
    parameter int LEAD_ZEROS = 32,
    parameter int SYNC_BYTES = 3
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  cbbe_sts_t sts,
    output cbbe_cmd_t cmd
);

    localparam int CNT_MAX = (LEAD_ZEROS > SYNC_BYTES) ? LEAD_ZEROS : SYNC_BYTES;
    localparam int CNT_W   = $clog2(CNT_MAX + 1);

    typedef enum logic [7:0] {
        ST_IDLE = 8'b0000_0001,
        ST_ZERO = 8'b0000_0010,
        ST_SYNC = 8'b0000_0100,
        ST_STX  = 8'b0000_1000,
        ST_DATA = 8'b0001_0000,
        ST_ETX  = 8'b0010_0000,
        ST_CSLO = 8'b0100_0000,
        ST_CSHI = 8'b1000_0000
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        in_ready   = (state_reg == ST_IDLE);
        cmd.accept = in_ready & in_valid;
        cmd.emit   = (state_reg != ST_IDLE) & sts.out_free;
        cmd.kind   = KIND_ZERO;
        cmd.last   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.accept)
                begin
                    cnt_next   = '0;
                    state_next = sts.first_of_block ? ST_ZERO : ST_DATA;
                end
            end
            ST_ZERO:
            begin
                cmd.kind = KIND_ZERO;
                if (cmd.emit)
                begin
                    if (cnt_reg == CNT_W'(LEAD_ZEROS - 1))
                    begin
                        cnt_next   = '0;
                        state_next = ST_SYNC;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
            end
            ST_SYNC:
            begin
                cmd.kind = KIND_SYNC;
                if (cmd.emit)
                begin
                    if (cnt_reg == CNT_W'(SYNC_BYTES - 1))
                    begin
                        cnt_next   = '0;
                        state_next = ST_STX;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
            end
            ST_STX:
            begin
                cmd.kind = KIND_STX;
                if (cmd.emit)
                begin
                    state_next = ST_DATA;
                end
            end
            ST_DATA:
            begin
                cmd.kind = KIND_DATA;
                cmd.last = ~sts.end_of_block;
                if (cmd.emit)
                begin
                    state_next = sts.end_of_block ? ST_ETX : ST_IDLE;
                end
            end
            ST_ETX:
            begin
                cmd.kind = KIND_ETX;
                if (cmd.emit)
                begin
                    state_next = ST_CSLO;
                end
            end
            ST_CSLO:
            begin
                cmd.kind = KIND_CSUM_LO;
                if (cmd.emit)
                begin
                    state_next = ST_CSHI;
                end
            end
            ST_CSHI:
            begin
                cmd.kind = KIND_CSUM_HI;
                cmd.last = 1'b1;
                if (cmd.emit)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

FILE: design/cbbe_datapath.sv
// ----------------------------------------------------------------------------
// cbbe_datapath
// Line level, block position, running sum, byte select, biphase coder and
// the output register.
// ----------------------------------------------------------------------------
module cbbe_datapath
    import cbbe_pkg::*;
#(
    parameter int BLOCK_BYTES = 256
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  cbbe_cmd_t   cmd,
    output cbbe_sts_t   sts,
    input  logic [7:0]  data_byte,
    input  logic        out_ready,
    output logic        out_valid,
    output logic [15:0] half_bit_levels,
    output logic [7:0]  coded_byte,
    output logic [2:0]  byte_kind,
    output logic        last_of_run
);

    logic             line_level_reg, line_level_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [SUM_W-1:0] sum_reg, sum_next;
    logic             out_valid_reg, out_valid_next;
    logic [7:0]       data_reg;
    logic [15:0]      halves_reg;
    logic [7:0]       coded_reg;
    kind_t            kind_reg;
    logic             last_reg;

    logic [SUM_W-1:0] csum;
    logic [7:0]       sel_byte;
    coded_t           enc;

    assign csum = sum_reg + SUM_W'(CODE_ETX);

    always_comb
    begin
        case (cmd.kind)
            KIND_ZERO:    sel_byte = CODE_ZERO;
            KIND_SYNC:    sel_byte = CODE_SYNC;
            KIND_STX:     sel_byte = CODE_STX;
            KIND_DATA:    sel_byte = data_reg;
            KIND_ETX:     sel_byte = CODE_ETX;
            KIND_CSUM_LO: sel_byte = csum[7:0];
            KIND_CSUM_HI: sel_byte = csum[15:8];
            default:      sel_byte = CODE_ZERO;
        endcase
    end

    assign enc = biphase_encode(sel_byte, line_level_reg);

    assign sts.first_of_block = (pos_reg == '0);
    assign sts.end_of_block   = (pos_reg >= POS_W'(BLOCK_BYTES - 1));
    assign sts.out_free       = ~out_valid_reg | out_ready;

    always_comb
    begin
        line_level_next = line_level_reg;
        pos_next        = pos_reg;
        sum_next        = sum_reg;
        out_valid_next  = out_valid_reg & ~out_ready;
        // sum restarts with the block
        if (cmd.accept && sts.first_of_block)
        begin
            sum_next = '0;
        end
        if (cmd.emit)
        begin
            out_valid_next  = 1'b1;
            line_level_next = enc.level;
            if (cmd.kind == KIND_DATA)
            begin
                sum_next = sum_reg + SUM_W'(data_reg);
                pos_next = sts.end_of_block ? '0 : pos_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_level_reg <= 1'b1;
            pos_reg        <= '0;
            sum_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            line_level_reg <= line_level_next;
            pos_reg        <= pos_next;
            sum_reg        <= sum_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            data_reg <= data_byte;
        end
        if (cmd.emit)
        begin
            halves_reg <= enc.halves;
            coded_reg  <= sel_byte;
            kind_reg   <= cmd.kind;
            last_reg   <= cmd.last;
        end
    end

    assign out_valid       = out_valid_reg;
    assign half_bit_levels = halves_reg;
    assign coded_byte      = coded_reg;
    assign byte_kind       = kind_reg;
    assign last_of_run     = last_reg;

endmodule

FILE: test/tb_cassette_block_biphase_encoder.sv
// ----------------------------------------------------------------------------
// tb_cassette_block_biphase_encoder
// Feeds data bytes through the encoder with random gaps and output stalls, and
// predicts every framed, biphase-mark coded byte. Each coded beat that leaves
// is compared field by field with the oldest expected one.
// ----------------------------------------------------------------------------
module tb_cassette_block_biphase_encoder;
    import cbbe_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LEAD  = 32;
    localparam int SYNCS = 3;
    localparam int BLOCK = 256;

    typedef struct {
        logic [15:0] halves;
        logic [7:0]  value;
        kind_t       kind;
        logic        last;
    } coded_beat_t;

    // predicts the framed block and checks coded beats against it
    class tape_frame_board;
        bit          line_lvl;
        int unsigned pos;
        logic [15:0] sum;
        coded_beat_t pending_codes[$];
        int          mismatch_count;

        function new();
            line_lvl       = 1'b1;
            pos            = 0;
            sum            = '0;
            mismatch_count = 0;
        endfunction

        function void push_code(logic [7:0] value, kind_t kind);
            coded_beat_t c;
            logic        first_half;
            c.halves = '0;
            for (int k = 0; k < 8; k++)
            begin
                first_half        = ~line_lvl;
                c.halves[2*k]     = first_half;
                line_lvl          = first_half ^ value[k];
                c.halves[2*k+1]   = line_lvl;
            end
            c.value = value;
            c.kind  = kind;
            c.last  = 1'b0;
            pending_codes.push_back(c);
        endfunction

        function void take_byte(logic [7:0] b);
            logic [15:0] csum;
            if (pos == 0)
            begin
                repeat (LEAD) push_code(CODE_ZERO, KIND_ZERO);
                repeat (SYNCS) push_code(CODE_SYNC, KIND_SYNC);
                push_code(CODE_STX, KIND_STX);
                sum = '0;
            end
            push_code(b, KIND_DATA);
            sum = sum + {8'h00, b};
            if (pos >= BLOCK - 1)
            begin
                csum = sum + {8'h00, CODE_ETX};
                push_code(CODE_ETX, KIND_ETX);
                push_code(csum[7:0], KIND_CSUM_LO);
                push_code(csum[15:8], KIND_CSUM_HI);
                pos = 0;
            end
            else
                pos = pos + 1;
            pending_codes[pending_codes.size() - 1].last = 1'b1;
        endfunction

        function void flag(string msg);
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("%0t ERROR %s", $realtime, msg);
        endfunction

        function void check_coded(logic [15:0] h, logic [7:0] v, logic [2:0] k, logic l);
            coded_beat_t want;
            if (pending_codes.size() == 0)
            begin
                flag($sformatf("unexpected beat halves=%h byte=%h kind=%0d last=%b",
                               h, v, k, l));
                return;
            end
            want = pending_codes.pop_front();
            if (h !== want.halves || v !== want.value || k !== want.kind || l !== want.last)
                flag($sformatf({"beat mismatch exp halves=%h byte=%h kind=%0d last=%b",
                                " got halves=%h byte=%h kind=%0d last=%b"},
                               want.halves, want.value, want.kind, want.last, h, v, k, l));
        endfunction
    endclass

    logic clk;
    logic rst_n;
    bit   steady;

    cbbe_in_if  in_ch();
    cbbe_out_if out_ch();

    tape_frame_board frames = new();

    cassette_block_biphase_encoder #(
        .LEAD_ZEROS  (LEAD),
        .SYNC_BYTES  (SYNCS),
        .BLOCK_BYTES (BLOCK)
    ) uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // sink side: random back-pressure except in the steady stretch
    always @(negedge clk)
        out_ch.ready <= steady || ($urandom_range(0, 99) >= 11);

    always @(posedge clk)
        if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
            frames.check_coded(out_ch.half_bit_levels, out_ch.coded_byte,
                               out_ch.byte_kind, out_ch.last_of_run);

    // called at a falling edge, returns at the falling edge after the beat
    task automatic send_byte(input logic [7:0] b);
        while (!steady && $urandom_range(0, 99) < 11)
        begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.data_byte <= b;
        do
            @(posedge clk);
        while (in_ch.ready !== 1'b1);
        frames.take_byte(b);
        @(negedge clk);
    endtask

    initial
    begin
        logic [7:0] corner_bytes[$];
        logic [7:0] b;
        corner_bytes = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'hAA, 8'h55, 8'h7F, 8'hFE,
                         8'h0F, 8'hF0, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h16, 8'h03};
        rst_n           = 1'b0;
        steady          = 1'b0;
        in_ch.valid     = 1'b0;
        in_ch.data_byte = '0;
        out_ch.ready    = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (corner_bytes[i])
            send_byte(corner_bytes[i]);

        // enough to close the first block and open the next one
        for (int i = 0; i < 300; i++)
        begin
            steady = (i >= 120 && i < 200);
            case ($urandom_range(0, 9))
                0:       b = 8'hFF;
                1:       b = 8'h00;
                default: b = 8'($urandom_range(0, 255));
            endcase
            send_byte(b);
        end
        steady = 1'b0;
        in_ch.valid <= 1'b0;

        while (frames.pending_codes.size() != 0)
            @(posedge clk);
        repeat (LEAD + SYNCS + 16) @(posedge clk);

        if (frames.mismatch_count == 0 && frames.pending_codes.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        #200_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
